[src/easing_curve_interpolator_macros.svh]
// assertion macros shared by the easing curve interpolator modules
`ifndef EASING_CURVE_INTERPOLATOR_MACROS_SVH
`define EASING_CURVE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define ECINT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ECINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ecint_pkg.sv]
// shared types, widths and curve tables for the easing curve interpolator
`timescale 1ns / 1ps

package ecint_pkg;

  // field widths
  localparam int PROG_W = 13;
  localparam int VAL_W  = 16;
  localparam int DIFF_W = VAL_W + 1;
  localparam int RES_W  = 20;
  localparam int FRAC_W = 10;
  localparam int BASE_W = FRAC_W + 1;
  localparam int SQ_W   = 2 * FRAC_W + 1;
  localparam int CUBE_W = 3 * FRAC_W + 1;
  localparam int S_W    = FRAC_W;
  localparam int DMAG_W = 10;
  localparam int SEG_W  = 2;
  localparam int NUM_SEG = 4;
  localparam int PROD_W = DIFF_W + PROG_W;

  // pipeline depths
  localparam int SHAPE_STAGES = 5;
  localparam int LERP_STAGES  = 2;

  // progress scale
  localparam logic [BASE_W-1:0] PROGRESS_FULL = 11'd1024;
  localparam logic [BASE_W-1:0] PROGRESS_HALF = 11'd512;
  localparam logic [FRAC_W-1:0] FRAC_MASK     = 10'd1023;
  localparam int CUBE_SHIFT_OUT = 2 * FRAC_W;
  localparam int CUBE_SHIFT_IO  = 2 * FRAC_W - 2;

  // highest point of the spring curve
  localparam logic [BASE_W-1:0] SPRING_PEAK = 11'd1072;

  typedef enum logic [1:0] {
    MODE_LINEAR      = 2'd0,
    MODE_EASE_OUT    = 2'd1,
    MODE_EASE_IN_OUT = 2'd2,
    MODE_SPRING      = 2'd3
  } ecint_mode_t;

  typedef logic [SEG_W-1:0] ecint_seg_t;

  // spring keyframes
  localparam logic [BASE_W-1:0] KEY_TIME [NUM_SEG+1] =
    '{11'd0, 11'd512, 11'd768, 11'd896, 11'd1024};
  localparam logic [BASE_W-1:0] KEY_VALUE [NUM_SEG] =
    '{11'd0, 11'd870, 11'd1072, 11'd1012};
  localparam logic [3:0] SPAN_LOG2 [NUM_SEG] = '{4'd9, 4'd8, 4'd7, 4'd7};
  localparam logic [BASE_W:0] SPAN_X3 [NUM_SEG] =
    '{12'd1536, 12'd768, 12'd384, 12'd384};
  localparam logic [DMAG_W-1:0] DELTA_MAG [NUM_SEG] =
    '{10'd870, 10'd202, 10'd60, 10'd12};
  localparam logic DELTA_NEG [NUM_SEG] = '{1'b0, 1'b0, 1'b1, 1'b0};

  // start and difference carried beside the curve
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [VAL_W-1:0]  start;
  } ecint_side_t;

  // request from the curve stages to the interpolation stages
  typedef struct packed {
    logic [PROG_W-1:0] eased;
    ecint_side_t       side;
  } ecint_lerp_req_t;

endpackage

[src/ecint_shape.sv]
// five-stage curve pipeline: clamp, square, cube, scale, spring blend
`timescale 1ns / 1ps
`include "easing_curve_interpolator_macros.svh"

module ecint_shape (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ecint_pkg::ecint_mode_t              in_mode,
  input  logic signed [ecint_pkg::PROG_W-1:0] in_progress,
  input  ecint_pkg::ecint_side_t              in_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ecint_pkg::ecint_lerp_req_t          out_req
);
  import ecint_pkg::*;

  logic [SHAPE_STAGES-1:0] v_r, v_nxt, v_up;
  logic [SHAPE_STAGES:0]   stage_rdy;

  // stage 1 registers
  ecint_mode_t       mode1_r;
  logic [PROG_W-1:0] prog1_r;
  ecint_side_t       side1_r;
  logic [BASE_W-1:0] x1_r;
  ecint_seg_t        seg1_r;
  logic              upper1_r;
  // stage 2 registers
  ecint_mode_t       mode2_r;
  logic [PROG_W-1:0] prog2_r;
  ecint_side_t       side2_r;
  ecint_seg_t        seg2_r;
  logic              upper2_r;
  logic [SQ_W-1:0]   sq2_r;
  logic [BASE_W-1:0] mb2_r;
  // stage 3 registers
  ecint_mode_t       mode3_r;
  logic [PROG_W-1:0] prog3_r;
  ecint_side_t       side3_r;
  ecint_seg_t        seg3_r;
  logic              upper3_r;
  logic [CUBE_W-1:0] cube3_r;
  // stage 4 registers
  ecint_mode_t       mode4_r;
  ecint_side_t       side4_r;
  ecint_seg_t        seg4_r;
  logic [PROG_W-1:0] e4_r;
  // stage 5 registers
  ecint_mode_t       mode5_r;
  ecint_side_t       side5_r;
  logic [PROG_W-1:0] e5_r;

  // next values
  logic [BASE_W-1:0]          clamp_c;
  logic [BASE_W-1:0]          x_nxt;
  ecint_seg_t                 seg_nxt;
  logic                       upper_nxt;
  logic [2*BASE_W-1:0]        sq_full;
  logic [BASE_W:0]            w_c;
  logic [BASE_W-1:0]          mb_nxt;
  logic [SQ_W+BASE_W-1:0]     cube_full;
  logic [PROG_W-1:0]          cq_out, cq_io, spr_s;
  logic [PROG_W-1:0]          e4_nxt;
  logic [S_W+DMAG_W-1:0]      blend_mag;
  logic [PROG_W-1:0]          blend_q;
  logic [PROG_W-1:0]          e5_nxt;

  // ready ripples back from the output; a bubble lets upstream move
  assign v_up = {v_r[SHAPE_STAGES-2:0], in_valid};
  always_comb begin
    stage_rdy[SHAPE_STAGES] = out_ready;
    for (int k = SHAPE_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !v_r[k] || stage_rdy[k+1];
    end
    for (int k = 0; k < SHAPE_STAGES; k++) begin
      v_nxt[k] = stage_rdy[k] ? v_up[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = stage_rdy[0];

  // stage 1: clamp, pick spring segment, form the cube base
  always_comb begin
    if (in_progress < 0) begin
      clamp_c = '0;
    end else if (in_progress > $signed({2'b00, PROGRESS_FULL})) begin
      clamp_c = PROGRESS_FULL;
    end else begin
      clamp_c = in_progress[BASE_W-1:0];
    end
    seg_nxt = '0;
    for (int k = NUM_SEG - 1; k >= 0; k--) begin
      if (clamp_c <= KEY_TIME[k+1]) begin
        seg_nxt = SEG_W'(k);
      end
    end
    upper_nxt = (clamp_c >= PROGRESS_HALF);
    unique case (in_mode)
      MODE_EASE_OUT:    x_nxt = PROGRESS_FULL - clamp_c;
      MODE_EASE_IN_OUT: x_nxt = upper_nxt ? (PROGRESS_FULL - clamp_c) : clamp_c;
      MODE_SPRING:      x_nxt = clamp_c - KEY_TIME[seg_nxt];
      MODE_LINEAR:      x_nxt = '0;
    endcase
  end

  // stage 2: square, and the second factor (base or smoothstep weight)
  always_comb begin
    sq_full = x1_r * x1_r;
    w_c     = SPAN_X3[seg1_r] - {x1_r, 1'b0};
    mb_nxt  = (mode1_r == MODE_SPRING) ? w_c[BASE_W-1:0] : x1_r;
  end

  // stage 3: cube or t*t*(3span-2t)
  assign cube_full = sq2_r * mb2_r;

  // stage 4: scale down per curve
  always_comb begin
    cq_out = PROG_W'(cube3_r >> CUBE_SHIFT_OUT);
    cq_io  = PROG_W'(cube3_r >> CUBE_SHIFT_IO);
    spr_s  = PROG_W'(cube3_r >> {SPAN_LOG2[seg3_r], 1'b0});
    unique case (mode3_r)
      MODE_EASE_OUT:    e4_nxt = {2'b00, PROGRESS_FULL} - cq_out;
      MODE_EASE_IN_OUT: e4_nxt = upper3_r ? ({2'b00, PROGRESS_FULL} - cq_io) : cq_io;
      MODE_SPRING:      e4_nxt = spr_s;
      MODE_LINEAR:      e4_nxt = prog3_r;
    endcase
  end

  // stage 5: blend the spring segment between its keyframe values
  always_comb begin
    blend_mag = S_W'(e4_r) * DELTA_MAG[seg4_r];
    blend_q   = PROG_W'(blend_mag >> SPAN_LOG2[seg4_r]);
    if (mode4_r == MODE_SPRING) begin
      e5_nxt = DELTA_NEG[seg4_r] ? ({2'b00, KEY_VALUE[seg4_r]} - blend_q)
                                 : ({2'b00, KEY_VALUE[seg4_r]} + blend_q);
    end else begin
      e5_nxt = e4_r;
    end
  end

  // payload registers advance with their stage
  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      mode1_r  <= in_mode;
      prog1_r  <= in_progress;
      side1_r  <= in_side;
      x1_r     <= x_nxt;
      seg1_r   <= seg_nxt;
      upper1_r <= upper_nxt;
    end
    if (stage_rdy[1]) begin
      mode2_r  <= mode1_r;
      prog2_r  <= prog1_r;
      side2_r  <= side1_r;
      seg2_r   <= seg1_r;
      upper2_r <= upper1_r;
      sq2_r    <= sq_full[SQ_W-1:0];
      mb2_r    <= mb_nxt;
    end
    if (stage_rdy[2]) begin
      mode3_r  <= mode2_r;
      prog3_r  <= prog2_r;
      side3_r  <= side2_r;
      seg3_r   <= seg2_r;
      upper3_r <= upper2_r;
      cube3_r  <= cube_full[CUBE_W-1:0];
    end
    if (stage_rdy[3]) begin
      mode4_r <= mode3_r;
      side4_r <= side3_r;
      seg4_r  <= seg3_r;
      e4_r    <= e4_nxt;
    end
    if (stage_rdy[4]) begin
      mode5_r <= mode4_r;
      side5_r <= side4_r;
      e5_r    <= e5_nxt;
    end
  end

  assign out_valid     = v_r[SHAPE_STAGES-1];
  assign out_req.eased = e5_r;
  assign out_req.side  = side5_r;

  // curve results stay in range, stalled items hold
  `ECINT_ASSERT_NOW(a_spring_range, v_r[SHAPE_STAGES-1] && mode5_r == MODE_SPRING, e5_r <= PROG_W'(SPRING_PEAK), "spring output out of range")
  `ECINT_ASSERT_NOW(a_cubic_range, v_r[SHAPE_STAGES-1] && (mode5_r == MODE_EASE_OUT || mode5_r == MODE_EASE_IN_OUT), e5_r <= PROG_W'(PROGRESS_FULL), "cubic output out of range")
  `ECINT_ASSERT_NEXT(a_stall_hold, v_r[SHAPE_STAGES-1] && !out_ready, v_r[SHAPE_STAGES-1] && $stable(e5_r), "stalled curve result changed")

endmodule

[src/ecint_lerp.sv]
// two-stage interpolation: difference times eased progress, then scale and add
`timescale 1ns / 1ps
`include "easing_curve_interpolator_macros.svh"

module ecint_lerp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ecint_pkg::ecint_lerp_req_t         in_req,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ecint_pkg::PROG_W-1:0]       out_eased,
  output logic signed [ecint_pkg::RES_W-1:0] out_result
);
  import ecint_pkg::*;

  logic [LERP_STAGES-1:0] v_r, v_nxt, v_up;
  logic [LERP_STAGES:0]   stage_rdy;

  logic signed [PROD_W-1:0]        prod6_r;
  logic [PROG_W-1:0]               eased6_r;
  logic signed [VAL_W-1:0]         start6_r;
  logic signed [RES_W-1:0]         res7_r;
  logic [PROG_W-1:0]               eased7_r;

  logic signed [PROD_W-1:0]        prod_nxt;
  logic signed [PROD_W-1:0]        adj_c;
  logic signed [PROD_W-FRAC_W-1:0] quot_c;
  logic signed [RES_W-1:0]         res_nxt;

  // ready chain and valid bits
  assign v_up = {v_r[LERP_STAGES-2:0], in_valid};
  always_comb begin
    stage_rdy[LERP_STAGES] = out_ready;
    for (int k = LERP_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !v_r[k] || stage_rdy[k+1];
    end
    for (int k = 0; k < LERP_STAGES; k++) begin
      v_nxt[k] = stage_rdy[k] ? v_up[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = stage_rdy[0];

  // stage 6: signed product of difference and eased progress
  assign prod_nxt = $signed(in_req.side.diff) * $signed(in_req.eased);

  // stage 7: divide by the full scale toward zero, add start
  always_comb begin
    adj_c   = prod6_r[PROD_W-1] ? (prod6_r + $signed({{(PROD_W-FRAC_W){1'b0}}, FRAC_MASK}))
                                : prod6_r;
    quot_c  = adj_c[PROD_W-1:FRAC_W];
    res_nxt = RES_W'(quot_c) + RES_W'(start6_r);
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      prod6_r  <= prod_nxt;
      eased6_r <= in_req.eased;
      start6_r <= in_req.side.start;
    end
    if (stage_rdy[1]) begin
      res7_r   <= res_nxt;
      eased7_r <= eased6_r;
    end
  end

  assign out_valid  = v_r[LERP_STAGES-1];
  assign out_eased  = eased7_r;
  assign out_result = res7_r;

  // zero progress must give back the start value exactly
  `ECINT_ASSERT_NEXT(a_zero_gives_start, v_r[0] && stage_rdy[1] && eased6_r == '0, res7_r == RES_W'($past(start6_r)), "zero progress did not return start")

endmodule

[src/easing_curve_interpolator.sv]
// Easing curve interpolator: one request per clock unless out_ready stalls the
// pipeline. Each request carries a curve mode, a progress value (1024 =
// complete) and a start and target value; the result carries the eased progress
// and start + (target - start) * eased / 1024, truncated toward zero. Linear
// mode passes progress through unclamped; the three curves clamp it to
// 0..1024. The pipeline has five curve stages (clamp, square, cube, scale,
// spring blend multiply) and two interpolation stages (product, then scale and
// add). Every stage holds its request under backpressure and empty stages fill,
// so in_ready follows out_ready combinationally through the stage ready chain.
// No state links requests and reset only clears the valid bits.
`timescale 1ns / 1ps

module easing_curve_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic signed [ecint_pkg::PROG_W-1:0] in_progress,
  input  logic signed [ecint_pkg::VAL_W-1:0]  in_start_value,
  input  logic signed [ecint_pkg::VAL_W-1:0]  in_target_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ecint_pkg::PROG_W-1:0] out_eased_progress,
  output logic signed [ecint_pkg::RES_W-1:0]  out_result_value
);
  import ecint_pkg::*;

  ecint_side_t       side_c;
  ecint_lerp_req_t   lerp_req;
  logic              lerp_valid, lerp_ready;
  logic [PROG_W-1:0] eased_c;

  // difference to the target, one bit wider than the values
  assign side_c.diff  = DIFF_W'(in_target_value) - DIFF_W'(in_start_value);
  assign side_c.start = in_start_value;

  // curve pipeline
  ecint_shape u_shape (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (ecint_mode_t'(in_mode)),
    .in_progress(in_progress),
    .in_side    (side_c),
    .out_valid  (lerp_valid),
    .out_ready  (lerp_ready),
    .out_req    (lerp_req)
  );

  // interpolation pipeline
  ecint_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lerp_valid),
    .in_ready  (lerp_ready),
    .in_req    (lerp_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_eased (eased_c),
    .out_result(out_result_value)
  );

  assign out_eased_progress = $signed(eased_c);

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the easing curve interpolator, with its own curve predictor

module testbench;
  import ecint_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam longint UNIT       = 1024;
  localparam int KEY_TIMES [5]  = '{0, 512, 768, 896, 1024};

  typedef struct {
    logic signed [PROG_W-1:0] eased;
    logic signed [RES_W-1:0]  value;
  } easing_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_mode = MODE_LINEAR;
  logic signed [PROG_W-1:0]   in_progress = '0;
  logic signed [VAL_W-1:0]    in_start_value = '0;
  logic signed [VAL_W-1:0]    in_target_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [PROG_W-1:0]   out_eased_progress;
  logic signed [RES_W-1:0]    out_result_value;

  easing_result_t pending_results [$];
  int mismatch_count = 0;
  int request_count = 0;
  int checked_count = 0;
  int mode_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit send_idle_en = 1'b0;
  bit rcv_idle_en = 1'b0;

  easing_curve_interpolator DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_progress        (in_progress),
    .in_start_value     (in_start_value),
    .in_target_value    (in_target_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_eased_progress (out_eased_progress),
    .out_result_value   (out_result_value)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // curve prediction
  function automatic longint clamp_unit(longint p);
    if (p < 0) return 0;
    if (p > UNIT) return UNIT;
    return p;
  endfunction

  // smoothstep blend between two keyframe values over one segment
  function automatic longint keyframe_blend(longint a, longint b, longint t, longint span);
    longint s;
    s = (t * t * (3 * span - 2 * t)) / (span * span);
    return a + ((b - a) * s) / span;
  endfunction

  function automatic easing_result_t predict_easing(ecint_mode_t mode, longint p,
                                                    longint sv, longint tv);
    longint c;
    longint r;
    longint e;
    longint v;
    easing_result_t res;
    c = clamp_unit(p);
    case (mode)
      MODE_EASE_OUT: begin
        r = UNIT - c;
        e = UNIT - (r * r * r) / (UNIT * UNIT);
      end
      MODE_EASE_IN_OUT: begin
        r = UNIT - c;
        if (c < UNIT / 2) e = (4 * c * c * c) / (UNIT * UNIT);
        else e = UNIT - (4 * r * r * r) / (UNIT * UNIT);
      end
      MODE_SPRING: begin
        // a keyframe time belongs to the segment ending there
        if (c <= 512) e = keyframe_blend(0, 870, c, 512);
        else if (c <= 768) e = keyframe_blend(870, 1072, c - 512, 256);
        else if (c <= 896) e = keyframe_blend(1072, 1012, c - 768, 128);
        else e = keyframe_blend(1012, 1024, c - 896, 128);
      end
      default: e = p;
    endcase
    v = sv + ((tv - sv) * e) / UNIT;
    res.eased = e[PROG_W-1:0];
    res.value = v[RES_W-1:0];
    return res;
  endfunction

  // random field values
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // progress mostly in range, clustered around the keyframe times
  function automatic logic signed [PROG_W-1:0] pick_curve_progress();
    int k;
    k = $urandom_range(0, 4);
    case ($urandom_range(0, 2))
      0: return PROG_W'($urandom_range(0, 1024));
      1: return PROG_W'(KEY_TIMES[k] + int'($urandom_range(0, 4)) - 2);
      default: return PROG_W'(int'($urandom_range(0, 1200)) - 88);
    endcase
  endfunction

  function automatic ecint_mode_t pick_mode();
    return ecint_mode_t'($urandom_range(0, 3));
  endfunction

  // send one request, with an optional idle burst ahead of it
  task automatic send_request(ecint_mode_t mode, logic signed [PROG_W-1:0] prog,
                              logic signed [VAL_W-1:0] sv, logic signed [VAL_W-1:0] tv);
    int gap;
    gap = 0;
    if (send_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_progress     <= prog;
    in_start_value  <= sv;
    in_target_value <= tv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_easing(mode, prog, sv, tv));
    request_count++;
    mode_count[mode]++;
  endtask

  // hold off the sender until every result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // corners of every field, every curve, every keyframe boundary
  task automatic test_directed_extremes();
    send_request(MODE_LINEAR, -4096, -32768, 32767);
    send_request(MODE_LINEAR, 4095, 32767, -32768);
    send_request(MODE_LINEAR, 0, 100, -100);
    send_request(MODE_LINEAR, 1024, -32768, 32767);
    send_request(MODE_EASE_OUT, -4096, 1000, 2000);
    send_request(MODE_EASE_OUT, 0, -7, 7);
    send_request(MODE_EASE_OUT, 512, -500, 700);
    send_request(MODE_EASE_OUT, 1024, 32767, -32768);
    send_request(MODE_EASE_OUT, 4095, 0, 1);
    send_request(MODE_EASE_IN_OUT, -1, 5, 9);
    send_request(MODE_EASE_IN_OUT, 511, -32768, 32767);
    send_request(MODE_EASE_IN_OUT, 512, 32767, -32768);
    send_request(MODE_EASE_IN_OUT, 1025, 1234, -4321);
    send_request(MODE_SPRING, 0, 300, -300);
    send_request(MODE_SPRING, 300, -32768, 32767);
    send_request(MODE_SPRING, 512, 0, 1000);
    send_request(MODE_SPRING, 513, 1000, -1000);
    send_request(MODE_SPRING, 768, -32768, 32767);
    send_request(MODE_SPRING, 800, 32767, -32768);
    send_request(MODE_SPRING, 896, -20000, 20000);
    send_request(MODE_SPRING, 900, 20000, -20000);
    send_request(MODE_SPRING, 1024, -1, 1);
    send_request(MODE_SPRING, 4095, 555, -555);
  endtask

  // short bursts, each followed by a full drain of the pipeline
  task automatic test_drain_pause();
    send_idle_en = 1'b1;
    rcv_idle_en  = 1'b1;
    repeat (3) begin
      repeat (20) send_request(pick_mode(), PROG_W'($urandom), pick_value(), pick_value());
      wait_all_results();
    end
  endtask

  // full-range random requests, idling switched on and off in stretches
  task automatic test_random_full(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        send_idle_en = $urandom_range(0, 2) != 0;
        rcv_idle_en  = $urandom_range(0, 2) != 0;
      end
      send_request(pick_mode(), PROG_W'($urandom), pick_value(), pick_value());
    end
  endtask

  // curve modes with progress near the clamp points and keyframes
  task automatic test_curve_keyframes(int count);
    send_idle_en = 1'b1;
    rcv_idle_en  = 1'b1;
    repeat (count) begin
      send_request(ecint_mode_t'($urandom_range(1, 3)), pick_curve_progress(),
                   pick_value(), pick_value());
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_streaming(int count);
    send_idle_en = 1'b0;
    rcv_idle_en  = 1'b0;
    repeat (count) send_request(pick_mode(), PROG_W'($urandom), pick_value(), pick_value());
  endtask

  // result receiver with random stall bursts
  always begin
    @(posedge clk);
    if (rcv_idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    easing_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result eased=%0d value=%0d",
                                out_eased_progress, out_result_value));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_eased_progress !== want.eased)
          note_mismatch($sformatf("eased_progress expected %0d got %0d",
                                  want.eased, out_eased_progress));
        if (out_result_value !== want.value)
          note_mismatch($sformatf("result_value expected %0d got %0d",
                                  want.value, out_result_value));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_en = 1'b1;
    rcv_idle_en  = 1'b1;
    test_directed_extremes();
    test_drain_pause();
    test_random_full(600);
    test_curve_keyframes(220);
    test_streaming(270);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) note_mismatch("predictions left without a result");
    $display("covered %0d requests: linear %0d, ease-out %0d, ease-in-out %0d, spring %0d",
             request_count, mode_count[MODE_LINEAR], mode_count[MODE_EASE_OUT],
             mode_count[MODE_EASE_IN_OUT], mode_count[MODE_SPRING]);
    $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
